/* src/lse_pkg.sv */
// Package for the LIFO stack engine: sizes, operation and status codes,
// and the structs for the sequencer's memory requests and for its results.
// No dependencies.
package lse_pkg;

    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int DUMP_MAX    = (MAX_RESULTS < DEPTH) ? MAX_RESULTS : DEPTH;

    localparam int DATA_W      = 32;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int OUT_FILL_W  = 7;
    localparam int STATUS_W    = 2;

    localparam int IN_TDATA_W  = DATA_W;
    localparam int IN_TUSER_W  = 8 * ((FUNC_W + 7) / 8);
    localparam int OUT_PAY_W   = DATA_W + OUT_FILL_W + STATUS_W;
    localparam int OUT_TDATA_W = 8 * ((OUT_PAY_W + 7) / 8);

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH  = 3'd0,
        F_POP   = 3'd1,
        F_SWAP  = 3'd2,
        F_CLEAR = 3'd3,
        F_DUMP  = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FEW   = 2'd3
    } t_status;

    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } t_mem_req;

    typedef struct packed {
        logic                  valid;
        logic [DATA_W-1:0]     data;
        logic [OUT_FILL_W-1:0] fill;
        t_status               status;
        logic                  last;
    } t_result;

endpackage

/* src/lifo_stack_engine.sv */
// Push, pop, clear and unknown commands pass from decode to emit and then present their
// result from the result register; swap adds a read and two writes between, and a dump
// presents its entries one result at a time. The engine takes one command at a time, and
// a result stalled at the output holds the sequencer until it is taken.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending result;
// the entry memory itself is not cleared, since only written entries are ever read.
module lifo_stack_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Command side.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lse_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value
    input  logic [lse_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [2:0] func, rest zero
    // Result side.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lse_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] data, [38:32] fill,
                                                              // [40:39] status, rest zero
    output logic                               m_axis_tlast
);

    lse_pkg::t_mem_req           mem_req;
    lse_pkg::t_result            res;
    logic [lse_pkg::DATA_W-1:0]  rd_data;

    // The sequencer owns the fill count and the result register, so a
    // finished result can sit at the output while the stack is idle.
    lse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser[lse_pkg::FUNC_W-1:0]),
        .i_value     (s_axis_tdata[lse_pkg::DATA_W-1:0]),
        .o_res       (res),
        .i_out_ready (m_axis_tready),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    // The entries live in one memory with a registered read port; every
    // access of a command goes through it in turn.
    lse_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rd_data)
    );

    // Pack the result fields from the lowest bit up and pad to whole bytes.
    assign m_axis_tvalid = res.valid;
    assign m_axis_tlast  = res.last;
    assign m_axis_tdata  = lse_pkg::OUT_TDATA_W'({res.status, res.fill, res.data});

endmodule

/* src/lse_mem.sv */
// Entry memory of the LIFO stack engine: one write port and one read port
// with registered read data. Depends on lse_pkg.
module lse_mem (
    input  logic                      i_clk,
    input  lse_pkg::t_mem_req         i_req,
    output logic [lse_pkg::DATA_W-1:0] o_rdata
);

    logic [lse_pkg::DATA_W-1:0] r_mem [lse_pkg::DEPTH];
    logic [lse_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lse_ctrl.sv */
// Sequencer of the LIFO stack engine: decodes one command, steps the
// memory port through its reads and writes, and holds the result register.
// Depends on lse_pkg.
module lse_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lse_pkg::FUNC_W-1:0]      i_func,
    input  logic [lse_pkg::DATA_W-1:0]      i_value,
    output lse_pkg::t_result                o_res,
    input  logic                            i_out_ready,
    output lse_pkg::t_mem_req               o_mem,
    input  logic [lse_pkg::DATA_W-1:0]      i_rd_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_SWRD  = 7'b0000100,
        S_SWWR1 = 7'b0001000,
        S_SWWR2 = 7'b0010000,
        S_DUMP  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [lse_pkg::FUNC_W-1:0]      r_func;
    logic [lse_pkg::DATA_W-1:0]      r_value;
    logic [lse_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [lse_pkg::AW-1:0]          r_idx, n_idx;
    logic [lse_pkg::AW-1:0]          r_last_idx, n_last_idx;
    logic [lse_pkg::DATA_W-1:0]      r_tmp, n_tmp;
    lse_pkg::t_status                r_stat, n_stat;
    logic                            r_use_rd, n_use_rd;
    lse_pkg::t_result                r_out, n_out;

    logic                            out_free;
    logic [lse_pkg::FILL_W-1:0]      dump_cnt;
    logic                            dump_end;

    assign out_free   = !r_out.valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_res      = r_out;
    assign dump_cnt   = (r_fill > lse_pkg::FILL_W'(lse_pkg::DUMP_MAX))
                        ? lse_pkg::FILL_W'(lse_pkg::DUMP_MAX) : r_fill;
    assign dump_end   = (r_idx == r_last_idx);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_tmp      = r_tmp;
        n_stat     = r_stat;
        n_use_rd   = r_use_rd;
        n_out      = r_out;
        n_out.valid = r_out.valid && !i_out_ready;
        o_mem      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_stat   = lse_pkg::ST_OK;
                n_use_rd = 1'b0;
                n_state  = S_EMIT;
                case (r_func)
                    lse_pkg::F_PUSH: begin
                        if (r_fill == lse_pkg::FILL_W'(lse_pkg::DEPTH)) begin
                            n_stat = lse_pkg::ST_FULL;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_fill[lse_pkg::AW-1:0];
                            o_mem.wdata = r_value;
                            n_fill      = r_fill + lse_pkg::FILL_W'(1);
                        end
                    end
                    lse_pkg::F_POP: begin
                        if (r_fill == '0) begin
                            n_stat = lse_pkg::ST_EMPTY;
                        end else begin
                            n_fill      = r_fill - lse_pkg::FILL_W'(1);
                            o_mem.re    = 1'b1;
                            o_mem.raddr = lse_pkg::AW'(r_fill - lse_pkg::FILL_W'(1));
                            n_use_rd    = 1'b1;
                        end
                    end
                    lse_pkg::F_SWAP: begin
                        if (r_fill < lse_pkg::FILL_W'(2)) begin
                            n_stat = lse_pkg::ST_FEW;
                        end else begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = lse_pkg::AW'(r_fill - lse_pkg::FILL_W'(1));
                            n_state     = S_SWRD;
                        end
                    end
                    lse_pkg::F_CLEAR: begin
                        n_fill = '0;
                    end
                    lse_pkg::F_DUMP: begin
                        if (r_fill != '0) begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = '0;
                            n_idx       = '0;
                            n_last_idx  = lse_pkg::AW'(dump_cnt - lse_pkg::FILL_W'(1));
                            n_state     = S_DUMP;
                        end
                    end
                    default: begin
                        // Unknown commands leave the stack alone.
                    end
                endcase
            end
            S_SWRD: begin
                n_tmp       = i_rd_data;
                o_mem.re    = 1'b1;
                o_mem.raddr = lse_pkg::AW'(r_fill - lse_pkg::FILL_W'(2));
                n_state     = S_SWWR1;
            end
            S_SWWR1: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = lse_pkg::AW'(r_fill - lse_pkg::FILL_W'(1));
                o_mem.wdata = i_rd_data;
                n_state     = S_SWWR2;
            end
            S_SWWR2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = lse_pkg::AW'(r_fill - lse_pkg::FILL_W'(2));
                o_mem.wdata = r_tmp;
                n_state     = S_EMIT;
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out.valid  = 1'b1;
                    n_out.data   = i_rd_data;
                    n_out.fill   = lse_pkg::OUT_FILL_W'(r_fill);
                    n_out.status = lse_pkg::ST_OK;
                    n_out.last   = dump_end;
                    if (dump_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx       = r_idx + lse_pkg::AW'(1);
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_idx + lse_pkg::AW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.valid  = 1'b1;
                    n_out.data   = r_use_rd ? i_rd_data : '0;
                    n_out.fill   = lse_pkg::OUT_FILL_W'(r_fill);
                    n_out.status = r_stat;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_out   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        r_idx        <= n_idx;
        r_last_idx   <= n_last_idx;
        r_tmp        <= n_tmp;
        r_stat       <= n_stat;
        r_use_rd     <= n_use_rd;
    end

endmodule

/* src/lse_checker.sv */
// Port-level checks for the LIFO stack engine, bound to its top level.
// Depends on lse_pkg.
module lse_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    logic [lse_pkg::DATA_W-1:0]     out_data;
    logic [lse_pkg::OUT_FILL_W-1:0] out_fill;
    logic [lse_pkg::STATUS_W-1:0]   out_stat;

    assign out_data = m_axis_tdata[lse_pkg::DATA_W-1:0];
    assign out_fill = m_axis_tdata[lse_pkg::DATA_W +: lse_pkg::OUT_FILL_W];
    assign out_stat = m_axis_tdata[lse_pkg::DATA_W + lse_pkg::OUT_FILL_W +: lse_pkg::STATUS_W];

    // A command is worked on alone: the port closes right after a transaction.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command port stayed open after a transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // A refused command yields a single result with zero data.
    a_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_stat != lse_pkg::ST_OK) |-> (m_axis_tlast && out_data == '0))
        else $error("refused command gave data or more results");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_fill <= lse_pkg::OUT_FILL_W'(lse_pkg::DEPTH)))
        else $error("fill count beyond the stack depth");

endmodule

bind lifo_stack_engine lse_checker u_lse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
